[hdl/prewitt_edge_magnitude_unit_assert.svh]
// Assertion macros for the RTL of the Prewitt edge unit, used by its job queue.
`ifndef PREWITT_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define PREWITT_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define PEM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define PEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pem_pkg.sv]
`default_nettype none
package pem_pkg;

  localparam int MAX_LINE = 1024;
  localparam int AW       = $clog2(MAX_LINE);
  localparam int WCW      = $clog2(MAX_LINE + 1);
  localparam int CFG_W_W  = 11;
  localparam int CFG_H_W  = 16;
  localparam int CFG_D_W  = 16;
  localparam int CFG_I_W  = 2;
  localparam int PIX_W    = 8;
  localparam int G_W      = 11;
  localparam int SQ_W     = 20;
  localparam int SUM_W    = 21;
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);
  localparam int OQ_CW    = 2;

  typedef enum logic [CFG_I_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    F_IDLE, F_PIX, F_PIX2, F_DR0, F_DR1, F_DR2
  } f_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SQ, B_SUM, B_ITER, B_DONE
  } b_state_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
    logic                  eor;
    logic                  eof;
    logic                  last;
  } job_t;

  typedef struct packed {
    logic empty;
    logic two_free;
  } jq_status_t;

  typedef struct packed {
    pix_t mag;
    logic eor;
    logic eof;
    logic last;
  } result_t;

  // Both Prewitt gradients of a 3x3 neighborhood given as three columns.
  function automatic job_t make_job(col_t l, col_t c, col_t r,
                                    logic eor, logic eof, logic last);
    job_t j;
    logic [G_W-1:0] tsum, bsum, lsum, rsum;
    tsum = G_W'(l.top) + G_W'(c.top) + G_W'(r.top);
    bsum = G_W'(l.bot) + G_W'(c.bot) + G_W'(r.bot);
    lsum = G_W'(l.top) + G_W'(l.mid) + G_W'(l.bot);
    rsum = G_W'(r.top) + G_W'(r.mid) + G_W'(r.bot);
    j.gx   = $signed(tsum) - $signed(bsum);
    j.gy   = $signed(lsum) - $signed(rsum);
    j.eor  = eor;
    j.eof  = eof;
    j.last = last;
    return j;
  endfunction

endpackage
`default_nettype wire

[hdl/prewitt_edge_magnitude_unit.sv]
// Prewitt edge magnitude unit. Grayscale pixels enter in raster order through a queue-like
// port (push/full) and rounded gradient magnitudes leave through another (empty/pop),
// row r being emitted while row r+1 arrives; after the last pixel of a frame one drain
// transaction releases each output of the final row. The front end takes one pixel or drain at a
// time and takes an extra step when it closes a row, since the end-of-row pixel yields two
// outputs; both read the line stores through their single registered port. The back end
// works on one output at a time, bounded by the bit-serial square root that settles one result
// bit per cycle while it iterates; it stalls before handing on a result while its output queue is full.
// A short job queue lets the front end run ahead of the back end. Configuration writes
// (index 0 image width, index 1 image height) must be issued only while the unit is idle;
// each accepted write restarts the frame, while line store contents are kept.
`default_nettype none
module prewitt_edge_magnitude_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic                        in_action,
  input  wire logic [pem_pkg::PIX_W-1:0]   in_pixel,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [pem_pkg::PIX_W-1:0]        out_magnitude,
  output logic                             out_end_of_row,
  output logic                             out_end_of_frame,
  output logic                             out_last_in_run,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pem_pkg::CFG_I_W-1:0] cfg_index,
  input  wire logic [pem_pkg::CFG_D_W-1:0] cfg_data
);

  // Jobs carry both gradients and the row and frame marks of one output.
  pem_pkg::jq_status_t jq_status;
  pem_pkg::job_t       jq_in_job, jq_head;
  logic                jq_push, jq_pop;

  // The front end owns the line stores, the window and the frame counters.
  pem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_action (in_action),
    .in_pixel  (in_pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .jq_status (jq_status),
    .jq_push   (jq_push),
    .jq_job    (jq_in_job)
  );

  pem_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (jq_in_job),
    .pop      (jq_pop),
    .head_job (jq_head),
    .status   (jq_status)
  );

  // The back end squares, sums and rounds the root, then holds results for the consumer.
  pem_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .jq_status        (jq_status),
    .jq_head          (jq_head),
    .jq_pop           (jq_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_magnitude    (out_magnitude),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame),
    .out_last_in_run  (out_last_in_run)
  );

endmodule
`default_nettype wire

[hdl/pem_jobq.sv]
`default_nettype none
module pem_jobq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pem_pkg::job_t     push_job,
  input  wire logic              pop,
  output pem_pkg::job_t          head_job,
  output pem_pkg::jq_status_t    status
);

  pem_pkg::job_t                  mem_r [pem_pkg::JQ_DEPTH];
  logic [pem_pkg::JQ_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [pem_pkg::JQ_CW-1:0]      count_r;

  assign head_job        = mem_r[rd_ptr_r];
  assign status.empty    = (count_r == '0);
  assign status.two_free = (count_r <= pem_pkg::JQ_CW'(pem_pkg::JQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

`include "prewitt_edge_magnitude_unit_assert.svh"

  `PEM_ASSERT_SAME(a_no_overflow, push && !pop, count_r != pem_pkg::JQ_CW'(pem_pkg::JQ_DEPTH), "job queue overflow")
  `PEM_ASSERT_SAME(a_no_underflow, pop, count_r != '0, "job queue underflow")
  `PEM_ASSERT_NEXT(a_count_hold, !push && !pop, $stable(count_r), "job queue count moved while idle")

endmodule
`default_nettype wire

[hdl/pem_front.sv]
`default_nettype none
module pem_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_action,
  input  wire logic [pem_pkg::PIX_W-1:0]     in_pixel,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pem_pkg::CFG_I_W-1:0]   cfg_index,
  input  wire logic [pem_pkg::CFG_D_W-1:0]   cfg_data,
  input  wire pem_pkg::jq_status_t           jq_status,
  output logic                               jq_push,
  output pem_pkg::job_t                      jq_job
);

  localparam int AW  = pem_pkg::AW;
  localparam int WCW = pem_pkg::WCW;

  pem_pkg::f_state_t state_r, state_nxt;

  logic [pem_pkg::CFG_W_W-1:0] width_r;
  logic [pem_pkg::CFG_H_W-1:0] height_r;
  logic [AW-1:0]               col_r;
  logic [pem_pkg::CFG_H_W-1:0] row_r;
  logic [WCW-1:0]              drain_r;
  pem_pkg::col_t               win1_r, win2_r;

  logic [AW-1:0] c_q_r, k_r;
  logic          row1_q_r, rowge1_q_r, last_q_r, cis1_q_r, w1_q_r, klast_r;
  pem_pkg::pix_t pix_q_r, rd_u_r, rd_m_r;
  pem_pkg::col_t dl_r, dc_r;

  pem_pkg::pix_t upper_mem [pem_pkg::MAX_LINE];
  pem_pkg::pix_t middle_mem [pem_pkg::MAX_LINE];

  logic [WCW-1:0]              w_eff;
  logic [AW-1:0]               w_m1, c_cur, kl_cur, kr_r;
  logic [pem_pkg::CFG_H_W-1:0] h_eff;
  logic                        accept, cfg_wr, pix_ok, drain_ok, h_is1;
  logic [AW-1:0]               rd_addr;
  pem_pkg::col_t               rd_col, new_col;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WCW'(1);
    end else if (32'(width_r) > 32'(pem_pkg::MAX_LINE)) begin
      w_eff = WCW'(pem_pkg::MAX_LINE);
    end else begin
      w_eff = WCW'(width_r);
    end
  end

  assign w_m1     = AW'(w_eff - 1'b1);
  assign h_eff    = (height_r == '0) ? pem_pkg::CFG_H_W'(1) : height_r;
  assign h_is1    = (h_eff == pem_pkg::CFG_H_W'(1));
  assign c_cur    = (WCW'(col_r) >= w_eff) ? w_m1 : col_r;
  assign kl_cur   = (drain_r == '0) ? '0 : AW'(drain_r - 1'b1);
  assign kr_r     = (WCW'(k_r) + 1'b1 >= w_eff) ? w_m1 : k_r + 1'b1;
  assign pix_ok   = (row_r < h_eff);
  assign drain_ok = !pix_ok && (drain_r < w_eff);

  assign cfg_ready = (state_r == pem_pkg::F_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready &&
                     (cfg_index == pem_pkg::REG_IMAGE_WIDTH ||
                      cfg_index == pem_pkg::REG_IMAGE_HEIGHT);
  assign in_full   = !((state_r == pem_pkg::F_IDLE) && jq_status.two_free);
  assign accept    = in_push && !in_full;

  assign rd_col.top = h_is1 ? rd_m_r : rd_u_r;
  assign rd_col.mid = rd_m_r;
  assign rd_col.bot = rd_m_r;

  assign new_col.top = row1_q_r ? rd_m_r : rd_u_r;
  assign new_col.mid = rd_m_r;
  assign new_col.bot = pix_q_r;

  always_comb begin
    state_nxt = state_r;
    jq_push   = 1'b0;
    jq_job    = pem_pkg::make_job(win1_r, win2_r, new_col, 1'b0, 1'b0, !last_q_r);
    rd_addr   = c_cur;
    case (state_r)
      pem_pkg::F_IDLE: begin
        if (accept && !in_action && pix_ok) begin
          state_nxt = pem_pkg::F_PIX;
        end else if (accept && in_action && drain_ok) begin
          rd_addr   = kl_cur;
          state_nxt = pem_pkg::F_DR0;
        end
      end
      pem_pkg::F_PIX: begin
        if (cis1_q_r) begin
          jq_job = pem_pkg::make_job(win2_r, win2_r, new_col, 1'b0, 1'b0, !last_q_r);
        end
        jq_push   = rowge1_q_r && (c_q_r != '0);
        state_nxt = (rowge1_q_r && last_q_r) ? pem_pkg::F_PIX2 : pem_pkg::F_IDLE;
      end
      pem_pkg::F_PIX2: begin
        jq_job    = pem_pkg::make_job(w1_q_r ? win2_r : win1_r, win2_r, win2_r,
                                      1'b1, 1'b0, 1'b1);
        jq_push   = 1'b1;
        state_nxt = pem_pkg::F_IDLE;
      end
      pem_pkg::F_DR0: begin
        rd_addr   = k_r;
        state_nxt = pem_pkg::F_DR1;
      end
      pem_pkg::F_DR1: begin
        rd_addr   = kr_r;
        state_nxt = pem_pkg::F_DR2;
      end
      pem_pkg::F_DR2: begin
        jq_job    = pem_pkg::make_job(dl_r, dc_r, rd_col, klast_r, klast_r, 1'b1);
        jq_push   = 1'b1;
        state_nxt = pem_pkg::F_IDLE;
      end
      default: begin
        state_nxt = pem_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pem_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Line stores: registered read, middle written at accept, upper in the cycle after.
  always_ff @(posedge clk) begin
    rd_u_r <= upper_mem[rd_addr];
    rd_m_r <= middle_mem[rd_addr];
    if (state_r == pem_pkg::F_IDLE && accept && !in_action && pix_ok) begin
      middle_mem[c_cur] <= in_pixel;
    end
    if (state_r == pem_pkg::F_PIX) begin
      upper_mem[c_q_r] <= rd_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pem_pkg::F_IDLE) begin
      c_q_r      <= c_cur;
      row1_q_r   <= (row_r == pem_pkg::CFG_H_W'(1));
      rowge1_q_r <= (row_r != '0);
      last_q_r   <= (c_cur == w_m1);
      cis1_q_r   <= (c_cur == AW'(1));
      w1_q_r     <= (w_eff == WCW'(1));
      pix_q_r    <= in_pixel;
      k_r        <= AW'(drain_r);
      klast_r    <= (AW'(drain_r) == w_m1);
    end
    if (state_r == pem_pkg::F_DR0) dl_r <= rd_col;
    if (state_r == pem_pkg::F_DR1) dc_r <= rd_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pem_pkg::CFG_W_W'(640);
      height_r <= pem_pkg::CFG_H_W'(480);
      col_r    <= '0;
      row_r    <= '0;
      drain_r  <= '0;
      win1_r   <= '0;
      win2_r   <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == pem_pkg::REG_IMAGE_WIDTH) begin
        width_r <= cfg_data[pem_pkg::CFG_W_W-1:0];
      end else begin
        height_r <= cfg_data;
      end
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
      win1_r  <= '0;
      win2_r  <= '0;
    end else begin
      case (state_r)
        pem_pkg::F_IDLE: begin
          if (accept && !in_action && pix_ok) begin
            if (WCW'(c_cur) + 1'b1 >= w_eff) begin
              col_r <= '0;
              row_r <= row_r + 1'b1;
            end else begin
              col_r <= c_cur + 1'b1;
            end
          end
        end
        pem_pkg::F_PIX: begin
          if (rowge1_q_r) begin
            win1_r <= win2_r;
            win2_r <= new_col;
          end
        end
        pem_pkg::F_DR2: begin
          if (drain_r + 1'b1 >= w_eff) begin
            col_r   <= '0;
            row_r   <= '0;
            drain_r <= '0;
            win1_r  <= '0;
            win2_r  <= '0;
          end else begin
            drain_r <= drain_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/pem_back.sv]
`default_nettype none
module pem_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pem_pkg::jq_status_t       jq_status,
  input  wire pem_pkg::job_t             jq_head,
  output logic                           jq_pop,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [pem_pkg::PIX_W-1:0]      out_magnitude,
  output logic                           out_end_of_row,
  output logic                           out_end_of_frame,
  output logic                           out_last_in_run
);

  pem_pkg::b_state_t state_r, state_nxt;

  pem_pkg::job_t                   job_r;
  logic [pem_pkg::SQ_W-1:0]        sqx_r, sqy_r;
  logic [pem_pkg::SUM_W-1:0]       s_r;
  pem_pkg::pix_t                   m_r, trial;
  logic [2:0]                      bit_r;
  logic signed [2*pem_pkg::G_W-1:0] px, py;
  logic [2*pem_pkg::PIX_W-1:0]     tsq;
  logic [2*pem_pkg::PIX_W:0]       tval;
  logic                            hit;

  pem_pkg::result_t                oq_r [2];
  logic                            oq_wr_r, oq_rd_r;
  logic [pem_pkg::OQ_CW-1:0]       oq_cnt_r;
  logic                            oq_push, oq_pop;
  pem_pkg::result_t                res;

  assign px    = job_r.gx * job_r.gx;
  assign py    = job_r.gy * job_r.gy;
  assign trial = m_r | (pem_pkg::PIX_W'(1) << bit_r);
  assign tsq   = trial * trial;
  assign tval  = {1'b0, tsq} + (2*pem_pkg::PIX_W+1)'(trial);
  assign hit   = (pem_pkg::SUM_W'(tval) < s_r);

  assign res.mag  = (s_r == '0) ? '0 : ((m_r == '1) ? m_r : m_r + 1'b1);
  assign res.eor  = job_r.eor;
  assign res.eof  = job_r.eof;
  assign res.last = job_r.last;

  always_comb begin
    state_nxt = state_r;
    jq_pop    = 1'b0;
    oq_push   = 1'b0;
    case (state_r)
      pem_pkg::B_IDLE: begin
        if (!jq_status.empty) begin
          jq_pop    = 1'b1;
          state_nxt = pem_pkg::B_SQ;
        end
      end
      pem_pkg::B_SQ:   state_nxt = pem_pkg::B_SUM;
      pem_pkg::B_SUM:  state_nxt = pem_pkg::B_ITER;
      pem_pkg::B_ITER: begin
        if (bit_r == '0) state_nxt = pem_pkg::B_DONE;
      end
      pem_pkg::B_DONE: begin
        if (oq_cnt_r != pem_pkg::OQ_CW'(2)) begin
          oq_push   = 1'b1;
          state_nxt = pem_pkg::B_IDLE;
        end
      end
      default: state_nxt = pem_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pem_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Square root rounded to nearest: find the largest m with m*m+m below s, one bit a cycle.
  always_ff @(posedge clk) begin
    case (state_r)
      pem_pkg::B_IDLE: job_r <= jq_head;
      pem_pkg::B_SQ: begin
        sqx_r <= px[pem_pkg::SQ_W-1:0];
        sqy_r <= py[pem_pkg::SQ_W-1:0];
      end
      pem_pkg::B_SUM: begin
        s_r   <= pem_pkg::SUM_W'(sqx_r) + pem_pkg::SUM_W'(sqy_r);
        m_r   <= '0;
        bit_r <= 3'd7;
      end
      pem_pkg::B_ITER: begin
        if (hit) m_r <= trial;
        bit_r <= bit_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_empty        = (oq_cnt_r == '0);
  assign oq_pop           = out_pop && !out_empty;
  assign out_magnitude    = oq_r[oq_rd_r].mag;
  assign out_end_of_row   = oq_r[oq_rd_r].eor;
  assign out_end_of_frame = oq_r[oq_rd_r].eof;
  assign out_last_in_run  = oq_r[oq_rd_r].last;

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) oq_wr_r <= !oq_wr_r;
      if (oq_pop)  oq_rd_r <= !oq_rd_r;
      if (oq_push && !oq_pop)      oq_cnt_r <= oq_cnt_r + 1'b1;
      else if (!oq_push && oq_pop) oq_cnt_r <= oq_cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire
